>>> rtl/pti_pkg.sv
// Package: shared types, constants and codes for the PVT table interpolator.
package pti_pkg;

    localparam int MaxPoints = 64;
    localparam int IdxBits   = $clog2(MaxPoints);
    localparam int ValBits   = 32;
    localparam int NumTab    = 7;
    localparam int QDepth    = 2;

    localparam logic [ValBits-1:0] OneQ16 = ValBits'(65536);
    localparam logic signed [ValBits-1:0] VMax = {1'b0, {(ValBits-1){1'b1}}};
    localparam logic signed [ValBits-1:0] VMin = {1'b1, {(ValBits-1){1'b0}}};

    typedef enum logic [1:0] {
        POL_FLAG  = 2'd0,
        POL_CLAMP = 2'd1,
        POL_EXTRA = 2'd2,
        POL_ALT   = 2'd3
    } t_policy;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BELOW  = 3'd1,
        ST_ABOVE  = 3'd2,
        ST_FACTOR = 3'd3,
        ST_RATIO  = 3'd4
    } t_status;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_VISC   = 2'd2;

    typedef enum logic [3:0] {
        BK_IDLE, BK_SRCH, BK_SRCH_W, BK_ROWS, BK_ROWS_W, BK_PREP,
        BK_VDIV, BK_SDIV, BK_NEXT, BK_FIN, BK_OUT
    } t_bk_state;

    // query as queued by the front end
    typedef struct packed {
        logic [31:0] pressure;
    } t_query;

    typedef struct packed {
        logic                 start;
        logic [ValBits+31:0]  num;
        logic [31:0]          den;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [ValBits+31:0] quo;
    } t_div_rsp;

endpackage

>>> rtl/pti_divider.sv
// Iterative restoring divider of an unsigned quotient; the caller pre-adds d/2 to round half up.
module pti_divider (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pti_pkg::t_div_req i_req,
    output pti_pkg::t_div_rsp o_rsp
);
    import pti_pkg::*;

    localparam int NB = ValBits + 32;
    localparam int CB = $clog2(NB + 1);

    logic [NB-1:0] r_num, n_num;
    logic [NB-1:0] r_quo, n_quo;
    logic [32:0]   r_rem, n_rem;
    logic [31:0]   r_den;
    logic [CB-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy, r_done, n_done;
    logic [32:0]   w_sh;

    // one quotient bit per cycle; numerator carries pre-added d/2
    always_comb begin
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem[31:0], r_num[NB-1]};
        if (i_req.start) begin
            n_num  = i_req.num;
            n_quo  = '0;
            n_rem  = '0;
            n_cnt  = CB'(NB);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[NB-2:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quo = {r_quo[NB-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[NB-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CB'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) r_den <= i_req.den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without busy");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_req.start |=> r_busy || r_done) else $error("divider lost work");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
`endif

endmodule

>>> rtl/pti_front.sv
// Front end: accepts items, writes load rows, queues queries.
module pti_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [5:0]  i_row_index,
    input  logic [31:0] i_pressure,
    input  logic [pti_pkg::NumTab-1:0][pti_pkg::ValBits-1:0] i_row,
    output logic        o_wr_en,
    output logic [pti_pkg::IdxBits-1:0] o_wr_addr,
    output logic [31:0] o_wr_pressure,
    output logic [pti_pkg::NumTab-1:0][pti_pkg::ValBits-1:0] o_wr_row,
    output logic        o_q_valid,
    output pti_pkg::t_query o_q_item,
    input  logic        i_q_pop,
    input  logic        i_bk_busy
);
    import pti_pkg::*;

    localparam int PB = $clog2(QDepth);

    t_query        r_fifo [QDepth];
    logic [PB-1:0] r_wp, r_rp;
    logic [PB:0]   r_cnt;
    logic          w_acc, w_push;

    // loads stall while queries are pending or in work so row order is kept
    assign o_stall = (r_cnt == (PB+1)'(QDepth)) ||
                     (!i_kind && (r_cnt != '0 || i_bk_busy)) || i_q_pop;
    assign w_acc   = i_valid && !o_stall;
    assign w_push  = w_acc && i_kind;

    assign o_wr_en       = w_acc && !i_kind;
    assign o_wr_addr     = i_row_index[IdxBits-1:0];
    assign o_wr_pressure = i_pressure;
    assign o_wr_row      = i_row;

    assign o_q_valid = r_cnt != '0;
    assign o_q_item  = r_fifo[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PB+1)'(w_push) - (PB+1)'(i_q_pop);
        end
        if (w_push) r_fifo[r_wp].pressure <= i_pressure;
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PB+1)'(QDepth)) else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != '0) else $error("queue underflow");
    a_load_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> r_cnt == '0 && !i_bk_busy) else $error("load passed a query");
`endif

endmodule

>>> rtl/pti_back.sv
// Back end: table memory, segment search, interpolation and result register.
module pti_back (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [pti_pkg::IdxBits-1:0] i_wr_addr,
    input  logic [31:0] i_wr_pressure,
    input  logic [pti_pkg::NumTab-1:0][pti_pkg::ValBits-1:0] i_wr_row,
    input  logic        i_q_valid,
    input  pti_pkg::t_query i_q_item,
    output logic        o_q_pop,
    output logic        o_busy,
    input  logic [1:0]  i_policy,
    input  logic [6:0]  i_count,
    input  logic        i_visc,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [10:0][pti_pkg::ValBits-1:0] o_res
);
    import pti_pkg::*;

    localparam int DB = ValBits + 1;        // |dv| width
    localparam int NB = ValBits + 32;

    // memories: grid plus seven tables, one read port
    logic [31:0]                        m_grid [MaxPoints];
    logic [NumTab-1:0][ValBits-1:0]     m_tab  [MaxPoints];
    logic [IdxBits-1:0]                 r_raddr, n_raddr;
    logic [31:0]                        r_rg;
    logic [NumTab-1:0][ValBits-1:0]     r_rt;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            m_grid[i_wr_addr] <= i_wr_pressure;
            m_tab[i_wr_addr]  <= i_wr_row;
        end
        r_rg <= m_grid[r_raddr];
        r_rt <= m_tab[r_raddr];
    end

    t_bk_state r_st, n_st;
    logic [31:0] r_p, n_p;
    logic [IdxBits:0] r_n, n_n, r_mid, n_mid, r_lower, n_lower;
    logic [31:0] r_g0, n_g0, r_gl, n_gl, r_lop, n_lop;
    logic [NumTab-1:0][ValBits-1:0] r_v0, n_v0;
    logic [1:0]  r_ph, n_ph;      // sub-phase for reads
    logic [2:0]  r_k, n_k;
    logic        r_below, n_below, r_above, n_above, r_dxneg, n_dxneg;
    logic        r_mode_cl, n_mode_cl;
    logic [31:0] r_dx, n_dx, r_d, n_d;
    logic [DB-1:0] r_dv, n_dv;
    logic        r_dvneg, n_dvneg;
    logic [2:0]  r_status, n_status;
    logic [10:0][ValBits-1:0] r_res, n_res;
    logic        r_ov, n_ov;
    logic [2:0]  r_ostatus, n_ostatus;
    logic [10:0][ValBits-1:0] r_ores, n_ores;
    t_div_req    r_req, n_req;
    t_div_rsp    w_rsp;
    logic [IdxBits:0] w_ncl;
    logic        w_edge;

    pti_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req), .o_rsp(w_rsp));

    assign w_ncl = (i_count < 7'd2) ? (IdxBits+1)'(2) :
                   (i_count > 7'(MaxPoints)) ? (IdxBits+1)'(MaxPoints) : (IdxBits+1)'(i_count);

    // saturating add of a signed base and a signed magnitude
    function automatic logic [ValBits-1:0] add_sat(input logic signed [ValBits-1:0] b,
                                                   input logic neg, input logic [NB-1:0] m);
        logic signed [NB+1:0] s;
        s = neg ? ($signed({{(NB+2-ValBits){b[ValBits-1]}}, b}) - $signed({2'b00, m}))
                : ($signed({{(NB+2-ValBits){b[ValBits-1]}}, b}) + $signed({2'b00, m}));
        if (s > $signed({{(NB+2-ValBits){1'b0}}, VMax})) return VMax;
        if (s < $signed({{(NB+2-ValBits){1'b1}}, VMin})) return VMin;
        return s[ValBits-1:0];
    endfunction

    logic [DB-1:0] w_dv; logic w_dvneg;
    logic signed [ValBits:0] w_a, w_b;
    assign w_a = $signed({r_v0[r_k][ValBits-1], r_v0[r_k]});
    assign w_b = $signed({r_rt[r_k][ValBits-1], r_rt[r_k]});
    assign w_dvneg = w_b < w_a;
    assign w_dv = w_dvneg ? DB'(w_a - w_b) : DB'(w_b - w_a);

    logic [NB-1:0] w_prod;
    assign w_prod = NB'(r_dv) * NB'(r_dx) + NB'(r_d >> 1);

    logic [NB-1:0] w_slopen;
    assign w_slopen = NB'(r_dv) + NB'(r_d >> 1);

    logic [2:0] w_used;
    assign w_used = i_visc ? 3'(NumTab) : 3'd4;

    // pressure at or past an end point needs no scan
    assign w_edge = (r_p >= r_gl) || !(r_p > r_g0);

    assign o_q_pop = (r_st == BK_IDLE) && i_q_valid;
    assign o_busy  = r_st != BK_IDLE;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE: if (i_q_valid) n_st = BK_SRCH;
            BK_SRCH: if (r_ph == 2'd2) n_st = BK_SRCH_W;
            BK_SRCH_W: begin
                if (r_below || r_above) n_st = (i_policy == POL_FLAG) ? BK_OUT : BK_ROWS;
                else if (w_edge) n_st = BK_ROWS;
                else if (r_ph == 2'd2 && r_rg <= r_p) n_st = BK_ROWS;
            end
            BK_ROWS: begin
                if (r_ph == 2'd1 && r_mode_cl) n_st = BK_FIN;
                else if (r_ph == 2'd2) n_st = (r_rg <= r_lop) ? BK_FIN : BK_PREP;
            end
            BK_PREP:   n_st = BK_ROWS_W;
            BK_ROWS_W: n_st = BK_VDIV;
            BK_VDIV: if (w_rsp.done) n_st = (r_k < 3'd4) ? BK_SDIV : BK_NEXT;
            BK_SDIV: if (w_rsp.done) n_st = BK_NEXT;
            BK_NEXT: n_st = (r_k + 3'd1 >= w_used) ? BK_FIN : BK_PREP;
            BK_FIN:  n_st = BK_OUT;
            BK_OUT: if (!r_ov || !i_stall) n_st = BK_IDLE;
            default: n_st = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_raddr   = r_raddr;
        n_p       = r_p;
        n_n       = r_n;
        n_mid     = r_mid;
        n_lower   = r_lower;
        n_g0      = r_g0;
        n_gl      = r_gl;
        n_lop     = r_lop;
        n_v0      = r_v0;
        n_ph      = r_ph;
        n_k       = r_k;
        n_below   = r_below;
        n_above   = r_above;
        n_dxneg   = r_dxneg;
        n_mode_cl = r_mode_cl;
        n_dx      = r_dx;
        n_d       = r_d;
        n_dv      = r_dv;
        n_dvneg   = r_dvneg;
        n_status  = r_status;
        n_res     = r_res;
        n_ov      = r_ov && i_stall;
        n_ostatus = r_ostatus;
        n_ores    = r_ores;
        n_req     = r_req;
        n_req.start = 1'b0;
        case (r_st)
            BK_IDLE: if (i_q_valid) begin
                n_p = i_q_item.pressure; n_n = w_ncl;
                n_raddr = '0; n_ph = 2'd0; n_res = '0; n_k = '0;
            end
            BK_SRCH: begin
                // read first and last grid points
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd0) n_raddr = IdxBits'(r_n - 1'b1);
                if (r_ph == 2'd1) n_g0 = r_rg;
                if (r_ph == 2'd2) begin
                    n_gl = r_rg;
                    n_below = r_p < r_g0;
                    n_above = !(r_p < r_g0) && r_p > r_rg;
                    n_mid = r_n - 2'd2;
                    n_ph = 2'd0;
                    n_lower = (r_p >= r_rg) ? r_n - 2'd2 : '0;
                end
            end
            BK_SRCH_W: begin
                if (r_below || r_above) begin
                    n_ph = 2'd0;
                    if (i_policy == POL_FLAG) begin
                        n_status = r_below ? ST_BELOW : ST_ABOVE;
                    end else if (i_policy == POL_CLAMP) begin
                        n_mode_cl = 1'b1;
                        n_raddr = r_below ? '0 : IdxBits'(r_n - 1'b1);
                    end else begin
                        n_mode_cl = 1'b0;
                        n_raddr = IdxBits'(r_lower);
                    end
                end else if (w_edge) begin
                    n_mode_cl = 1'b0; n_ph = 2'd0;
                    n_raddr = IdxBits'(r_lower);
                end else begin
                    // scan down from the top segment for grid[i] <= p
                    n_ph = r_ph + 2'd1;
                    if (r_ph == 2'd0) n_raddr = IdxBits'(r_mid);
                    if (r_ph == 2'd2) begin
                        n_ph = 2'd0;
                        if (r_rg <= r_p) begin
                            n_lower = r_mid; n_mode_cl = 1'b0;
                        end else begin
                            n_mid = r_mid - 1'b1;
                        end
                    end
                end
            end
            BK_ROWS: begin
                // read lower row, then upper row
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd0) n_raddr = r_raddr + 1'b1;
                if (r_ph == 2'd1) begin
                    n_lop = r_rg; n_v0 = r_rt;
                    if (r_mode_cl) begin
                        for (int j = 0; j < NumTab; j++)
                            if (3'(j) < w_used) n_res[j] = r_rt[j];
                    end
                end
                if (r_ph == 2'd2) begin
                    n_d = r_rg - r_lop;
                    n_dxneg = r_p < r_lop;
                    n_dx = (r_p < r_lop) ? r_lop - r_p : r_p - r_lop;
                    n_k = '0;
                    if (r_rg <= r_lop) begin
                        for (int j = 0; j < NumTab; j++)
                            if (3'(j) < w_used) n_res[j] = r_v0[j];
                    end
                end
            end
            BK_PREP: begin
                n_dv = w_dv; n_dvneg = w_dvneg;
            end
            BK_ROWS_W: begin
                n_req.start = 1'b1; n_req.num = w_prod; n_req.den = r_d;
            end
            BK_VDIV: if (w_rsp.done) begin
                n_res[r_k] = add_sat(r_v0[r_k], r_dvneg != r_dxneg, w_rsp.quo);
                if (r_k < 3'd4) begin
                    n_req.start = 1'b1; n_req.num = w_slopen; n_req.den = r_d;
                end
            end
            BK_SDIV: if (w_rsp.done) begin
                n_res[4'd7 + 4'(r_k)] = add_sat('0, r_dvneg, w_rsp.quo);
            end
            BK_NEXT: if (r_k + 3'd1 < w_used) n_k = r_k + 3'd1;
            BK_FIN: begin
                if (!i_visc) begin
                    n_res[4] = OneQ16; n_res[5] = OneQ16; n_res[6] = OneQ16;
                end
                if ($signed(r_res[0]) <= 0 || $signed(r_res[1]) <= 0 ||
                    $signed(r_res[2]) <= 0) n_status = ST_FACTOR;
                else if ($signed(r_res[3]) < 0) n_status = ST_RATIO;
                else n_status = ST_OK;
            end
            BK_OUT: if (!r_ov || !i_stall) begin
                n_ov = 1'b1; n_ostatus = r_status; n_ores = r_res;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= BK_IDLE;
            r_ov        <= 1'b0;
            r_raddr     <= '0;
            r_req.start <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_ov        <= n_ov;
            r_raddr     <= n_raddr;
            r_req.start <= n_req.start;
        end
        r_req.num <= n_req.num;
        r_req.den <= n_req.den;
        r_p       <= n_p;
        r_n       <= n_n;
        r_mid     <= n_mid;
        r_lower   <= n_lower;
        r_g0      <= n_g0;
        r_gl      <= n_gl;
        r_lop     <= n_lop;
        r_v0      <= n_v0;
        r_ph      <= n_ph;
        r_k       <= n_k;
        r_below   <= n_below;
        r_above   <= n_above;
        r_dxneg   <= n_dxneg;
        r_mode_cl <= n_mode_cl;
        r_dx      <= n_dx;
        r_d       <= n_d;
        r_dv      <= n_dv;
        r_dvneg   <= n_dvneg;
        r_status  <= n_status;
        r_res     <= n_res;
        r_ostatus <= n_ostatus;
        r_ores    <= n_ores;
    end

    assign o_valid  = r_ov;
    assign o_status = r_ostatus;
    assign o_res    = r_ores;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov) else $error("result dropped");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_st == BK_IDLE) else $error("pop while busy");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.busy |-> r_st == BK_VDIV || r_st == BK_SDIV) else $error("stray divide");
`endif

endmodule

>>> rtl/pvt_table_interpolator_core.sv
// Top level: PVT table interpolator, front end, queue and back end.
// Use: an input item with kind 0 writes one table row; kind 1 queries a
// pressure and yields one result item. Items use valid/stall handshakes;
// an item moves at an edge with valid high and stall low.
// Loads stall until queued and running queries finish.
// A query leaves the queue once the back end is idle; the end grid
// points are read first. An inner pressure then scans down from the
// top segment, one probe at a time (up to 63 probes), over the
// single-port table memory, and then the lower and upper rows are read.
// Each value takes a divide in the shared serial divider plus setup,
// and each of the four slopes one more divide. Flagged range errors
// go to the result register straight after the end-point reads, clamped
// ones after one row read; degenerate segments skip the divider.
// Queries run one at a time.
// A two-entry queue lets the next query be taken while one is in work;
// the result register holds a finished item while the receiver stalls.
// Configuration writes land at once; write only while idle.
// Reset (synchronous, active low) clears control state and registers to
// policy flag, two points, viscosity absent; table contents stay undefined.
module pvt_table_interpolator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [5:0]  i_row_index,
    input  logic [31:0] i_pressure,
    input  logic signed [31:0] i_water_factor_in,
    input  logic signed [31:0] i_oil_factor_in,
    input  logic signed [31:0] i_gas_factor_in,
    input  logic signed [31:0] i_gas_oil_ratio_in,
    input  logic signed [31:0] i_water_visc_in,
    input  logic signed [31:0] i_oil_visc_in,
    input  logic signed [31:0] i_gas_visc_in,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic signed [31:0] o_water_factor,
    output logic signed [31:0] o_oil_factor,
    output logic signed [31:0] o_gas_factor,
    output logic signed [31:0] o_gas_oil_ratio,
    output logic signed [31:0] o_water_visc,
    output logic signed [31:0] o_oil_visc,
    output logic signed [31:0] o_gas_visc,
    output logic signed [31:0] o_water_factor_slope,
    output logic signed [31:0] o_oil_factor_slope,
    output logic signed [31:0] o_gas_factor_slope,
    output logic signed [31:0] o_ratio_slope
);
    import pti_pkg::*;

    logic [1:0] r_policy;
    logic [6:0] r_count;
    logic       r_visc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FLAG;
            r_count  <= 7'd2;
            r_visc   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POLICY: r_policy <= i_cfg_data[1:0];
                CFG_COUNT:  r_count  <= i_cfg_data;
                CFG_VISC:   r_visc   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [NumTab-1:0][ValBits-1:0] w_row, w_wr_row;
    logic w_wr_en, w_q_valid, w_q_pop, w_bk_busy;
    logic [IdxBits-1:0] w_wr_addr;
    logic [31:0] w_wr_p;
    t_query w_q;
    logic [10:0][ValBits-1:0] w_res;

    assign w_row = {i_gas_visc_in, i_oil_visc_in, i_water_visc_in, i_gas_oil_ratio_in,
                    i_gas_factor_in, i_oil_factor_in, i_water_factor_in};

    pti_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_row_index(i_row_index), .i_pressure(i_pressure),
        .i_row(w_row), .o_wr_en(w_wr_en), .o_wr_addr(w_wr_addr),
        .o_wr_pressure(w_wr_p), .o_wr_row(w_wr_row), .o_q_valid(w_q_valid),
        .o_q_item(w_q), .i_q_pop(w_q_pop), .i_bk_busy(w_bk_busy)
    );

    pti_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr_en(w_wr_en), .i_wr_addr(w_wr_addr),
        .i_wr_pressure(w_wr_p), .i_wr_row(w_wr_row), .i_q_valid(w_q_valid),
        .i_q_item(w_q), .o_q_pop(w_q_pop), .o_busy(w_bk_busy), .i_policy(r_policy),
        .i_count(r_count), .i_visc(r_visc), .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_res(w_res)
    );

    assign o_water_factor       = w_res[0];
    assign o_oil_factor         = w_res[1];
    assign o_gas_factor         = w_res[2];
    assign o_gas_oil_ratio      = w_res[3];
    assign o_water_visc         = w_res[4];
    assign o_oil_visc           = w_res[5];
    assign o_gas_visc           = w_res[6];
    assign o_water_factor_slope = w_res[7];
    assign o_oil_factor_slope   = w_res[8];
    assign o_gas_factor_slope   = w_res[9];
    assign o_ratio_slope        = w_res[10];

endmodule

>>> tb/tb_pvt_table_interpolator_core.sv
// Testbench: checks the PVT table interpolator against a built-in predictor.
module tb_pvt_table_interpolator_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pti_pkg::*;

    typedef struct {
        logic [2:0]         status;
        logic signed [31:0] val [11];
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_kind;
    logic [5:0]  i_row_index;
    logic [31:0] i_pressure;
    logic signed [31:0] i_water_factor_in, i_oil_factor_in, i_gas_factor_in;
    logic signed [31:0] i_gas_oil_ratio_in, i_water_visc_in, i_oil_visc_in;
    logic signed [31:0] i_gas_visc_in;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [6:0]  i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic signed [31:0] o_water_factor, o_oil_factor, o_gas_factor, o_gas_oil_ratio;
    logic signed [31:0] o_water_visc, o_oil_visc, o_gas_visc;
    logic signed [31:0] o_water_factor_slope, o_oil_factor_slope;
    logic signed [31:0] o_gas_factor_slope, o_ratio_slope;

    pvt_table_interpolator_core dut (.*);

    // predictor state
    logic [31:0]        grid [64];
    logic signed [31:0] tbl [7][64];
    logic [1:0]         policy_q;
    logic [6:0]         count_q;
    logic               visc_q;
    t_answer            pending [$];

    int  send_pct;
    int  recv_pct;
    int  hold_cycles;
    int  errors;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    // receiver stall, with an optional long hold-off
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles = hold_cycles - 1;
                i_stall = 1'b1;
            end else begin
                i_stall = ($urandom_range(99) < recv_pct);
            end
        end
    end

    // add a magnitude to a base value, saturated to the signed range
    function automatic logic signed [31:0] sat_add(logic signed [31:0] base, bit neg,
                                                    logic [95:0] mag);
        logic signed [97:0] s;
        s = neg ? base - $signed({2'b0, mag}) : base + $signed({2'b0, mag});
        if (s > 98'sd2147483647) return VMax;
        if (s < -98'sd2147483648) return VMin;
        return s[31:0];
    endfunction

    // round(mag * mul / d), ties away from zero
    function automatic logic [95:0] rdiv(logic [32:0] mag, logic [31:0] mul,
                                         logic [31:0] d);
        logic [95:0] num;
        num = 96'(mag) * 96'(mul) + 96'(d >> 1);
        return num / 96'(d);
    endfunction

    // expected answer for a query at pressure p
    function automatic t_answer query_answer(logic [31:0] p);
        t_answer a;
        int n, lower, used;
        logic [31:0] g0, gl, lo_p, hi_p, d, dx;
        logic signed [31:0] v0, v1;
        logic [32:0] dv;
        bit below, above, dx_neg, dv_neg;
        n = count_q < 2 ? 2 : (count_q > 64 ? 64 : count_q);
        g0 = grid[0];
        gl = grid[n-1];
        below = p < g0;
        above = !below && p > gl;
        used = visc_q ? 7 : 4;
        a.status = ST_OK;
        foreach (a.val[k]) a.val[k] = '0;
        if ((below || above) && policy_q == POL_FLAG) begin
            a.status = below ? ST_BELOW : ST_ABOVE;
        end else if ((below || above) && policy_q == POL_CLAMP) begin
            for (int k = 0; k < used; k++) a.val[k] = tbl[k][below ? 0 : n-1];
        end else begin
            lower = 0;
            if (p >= gl) begin
                lower = n - 2;
            end else if (p > g0) begin
                for (int i = n - 2; i >= 0; i--) begin
                    if (grid[i] <= p) begin
                        lower = i;
                        break;
                    end
                end
            end
            lo_p = grid[lower];
            hi_p = grid[lower+1];
            if (hi_p <= lo_p) begin
                for (int k = 0; k < used; k++) a.val[k] = tbl[k][lower];
            end else begin
                d = hi_p - lo_p;
                dx_neg = p < lo_p;
                dx = dx_neg ? lo_p - p : p - lo_p;
                for (int k = 0; k < used; k++) begin
                    v0 = tbl[k][lower];
                    v1 = tbl[k][lower+1];
                    dv_neg = v1 < v0;
                    dv = dv_neg ? {v0[31], v0} - {v1[31], v1}
                                : {v1[31], v1} - {v0[31], v0};
                    a.val[k] = sat_add(v0, dv_neg != dx_neg, rdiv(dv, dx, d));
                    if (k < 4) a.val[7+k] = sat_add(0, dv_neg, rdiv(dv, 1, d));
                end
            end
        end
        if (a.status == ST_OK) begin
            if (!visc_q) begin
                a.val[4] = OneQ16;
                a.val[5] = OneQ16;
                a.val[6] = OneQ16;
            end
            if (a.val[0] <= 0 || a.val[1] <= 0 || a.val[2] <= 0) a.status = ST_FACTOR;
            else if (a.val[3] < 0) a.status = ST_RATIO;
        end
        return a;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_answer exp_a;
        logic signed [31:0] got [11];
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_water_factor, o_oil_factor, o_gas_factor, o_gas_oil_ratio,
                    o_water_visc, o_oil_visc, o_gas_visc, o_water_factor_slope,
                    o_oil_factor_slope, o_gas_factor_slope, o_ratio_slope};
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, status %0d", $time, o_status);
                errors++;
            end else begin
                exp_a = pending.pop_front();
                if (exp_a.status !== o_status) begin
                    $display("%0t: status expected %0d got %0d", $time, exp_a.status,
                             o_status);
                    errors++;
                end
                for (int k = 0; k < 11; k++) begin
                    if (exp_a.val[k] !== got[k]) begin
                        $display("%0t: field %0d expected %h got %h", $time, k,
                                 exp_a.val[k], got[k]);
                        errors++;
                    end
                end
            end
        end
    end

    // send one item; entered and left at a falling edge
    task automatic send_item(bit kind, logic [5:0] row, logic [31:0] p,
                             logic signed [31:0] v [7]);
        while ($urandom_range(99) < send_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_kind = kind;
        i_row_index = row;
        i_pressure = p;
        {i_water_factor_in, i_oil_factor_in, i_gas_factor_in, i_gas_oil_ratio_in,
         i_water_visc_in, i_oil_visc_in, i_gas_visc_in} = {v[0], v[1], v[2], v[3],
                                                            v[4], v[5], v[6]};
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        if (kind == 1'b0) begin
            grid[row] = p;
            for (int k = 0; k < 7; k++) tbl[k][row] = v[k];
        end else begin
            pending.push_back(query_answer(p));
        end
        @(negedge i_clk);
    endtask

    // table value: mostly positive, sometimes anything
    function automatic logic signed [31:0] any_value();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? VMax : VMin;
            2: return -$signed(32'($urandom_range(200000)));
            default: return 32'($urandom_range(32'h7FFFFF, 1));
        endcase
    endfunction

    task automatic load_row(int row, logic [31:0] p);
        logic signed [31:0] v [7];
        foreach (v[k]) v[k] = any_value();
        send_item(1'b0, row[5:0], p, v);
    endtask

    task automatic query(logic [31:0] p);
        logic signed [31:0] v [7];
        foreach (v[k]) v[k] = $urandom;
        send_item(1'b1, 6'($urandom), p, v);
    endtask

    // sorted grid over all 64 rows, saturating at the top
    task automatic load_grid(logic [31:0] start, int span);
        logic [32:0] p;
        p = 33'(start);
        for (int r = 0; r < 64; r++) begin
            load_row(r, p[31:0]);
            p = p + 33'($urandom_range(span, 0));
            if (p[32]) p = 33'hFFFFFFFF;
        end
    endtask

    // wait until nothing is outstanding, then let the block settle
    task automatic drain();
        i_valid = 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [6:0] data);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_POLICY: policy_q = data[1:0];
            CFG_COUNT:  count_q = data;
            CFG_VISC:   visc_q = data[0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_pressure();
        int n;
        n = count_q < 2 ? 2 : (count_q > 64 ? 64 : count_q);
        case ($urandom_range(9))
            0, 1: return $urandom;
            2: return grid[$urandom_range(n-1)];
            default: return grid[0] <= grid[n-1] ? $urandom_range(grid[n-1], grid[0])
                                                 : $urandom;
        endcase
    endfunction

    // directed: range ends, policies, special rows and extreme values
    task automatic test_directed();
        logic signed [31:0] v [7];
        load_grid(32'd1000, 5000);
        write_cfg(CFG_COUNT, 7'd2);
        query(32'd0);
        query(32'hFFFFFFFF);
        query(grid[0]);
        query(grid[1]);
        write_cfg(CFG_POLICY, 7'(POL_CLAMP));
        write_cfg(CFG_VISC, 7'd1);
        query(32'd0);
        query(32'hFFFFFFFF);
        write_cfg(CFG_POLICY, 7'(POL_EXTRA));
        query(32'd0);
        query(32'hFFFFFFFF);
        write_cfg(CFG_POLICY, 7'(POL_ALT));
        query(32'd3);
        // saturating extrapolation between extreme rows
        v = '{VMax, VMin, VMax, VMin, VMax, VMin, VMax};
        send_item(1'b0, 6'd0, 32'd10, v);
        v = '{VMin, VMax, VMin, VMax, VMin, VMax, VMin};
        send_item(1'b0, 6'd1, 32'd11, v);
        query(32'hFFFFFFFF);
        query(32'd0);
        // degenerate segment: equal pressures
        load_row(1, 32'd10);
        query(32'd10);
        // nonpositive factor and negative ratio
        v = '{32'sd0, 32'sd65536, 32'sd65536, 32'sd5, 32'sd1, 32'sd1, 32'sd1};
        send_item(1'b0, 6'd0, 32'd0, v);
        v = '{32'sd65536, 32'sd65536, 32'sd65536, -32'sd5, 32'sd1, 32'sd1, 32'sd1};
        send_item(1'b0, 6'd1, 32'hFFFFFFFF, v);
        query(32'd0);
        query(32'hFFFFFFFF);
        // counts outside the legal range
        write_cfg(CFG_COUNT, 7'd0);
        query(32'd5);
        write_cfg(CFG_COUNT, 7'd127);
        load_row(63, 32'hFFFFFFFF);
        query(32'h80000000);
        write_cfg(CFG_COUNT, 7'd64);
        query(grid[63]);
    endtask

    // random phase: grids reloaded now and then, mostly queries
    task automatic test_random(int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            case ($urandom_range(3))
                0: write_cfg(CFG_POLICY, 7'($urandom_range(3)));
                1: write_cfg(CFG_COUNT, 7'($urandom_range(3) == 0 ? $urandom_range(127)
                                                                  : $urandom_range(64, 2)));
                2: write_cfg(CFG_VISC, 7'($urandom_range(1)));
                default: ;
            endcase
            if ($urandom_range(2) == 0) begin
                load_grid($urandom_range(1) ? 32'd0 : $urandom,
                          $urandom_range(1) ? 50 : 32'h3FFFFFF);
                sent += 64;
            end
            repeat ($urandom_range(40, 10)) begin
                if ($urandom_range(9) == 0) load_row($urandom_range(63), $urandom);
                else query(pick_pressure());
                sent++;
            end
        end
    endtask

    // receiver holds off while queries keep coming
    task automatic test_backpressure();
        drain();
        hold_cycles = 3000;
        repeat (8) query(pick_pressure());
    endtask

    initial begin
        errors = 0;
        hold_cycles = 0;
        send_pct = 0;
        recv_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = 1'b0;
        i_row_index = '0;
        i_pressure = '0;
        {i_water_factor_in, i_oil_factor_in, i_gas_factor_in, i_gas_oil_ratio_in,
         i_water_visc_in, i_oil_visc_in, i_gas_visc_in} = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_POLICY;
        i_cfg_data = '0;
        policy_q = POL_FLAG;
        count_q = 7'd2;
        visc_q = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        send_pct = 28;
        recv_pct = 80;
        test_random(420);
        send_pct = 80;
        recv_pct = 28;
        test_random(420);
        send_pct = 0;
        recv_pct = 0;
        test_backpressure();
        test_random(420);

        drain();
        repeat (100) @(negedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/pti_pkg.sv
rtl/pti_divider.sv
rtl/pti_front.sv
rtl/pti_back.sv
rtl/pvt_table_interpolator_core.sv
tb/tb_pvt_table_interpolator_core.sv
